// File: rtl/knfe_pkg.sv
// ----------------------------------------------------------------------------
// knfe_pkg: shared types and constants for the KISS / NMEA frame encoder
// Byte codes, configuration register indexes, the job record passed from the
// front to the back, and the sequencer phases.
// ----------------------------------------------------------------------------
package knfe_pkg;

    // KISS special bytes
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // NMEA trailer characters
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    // Register reset values
    localparam logic [7:0] FRAME_TYPE_RST  = 8'h00;
    localparam logic [7:0] PREFIX_CHAR_RST = 8'h24;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHAR = 1'b1;

    // Job queue depth
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified input item
    typedef struct packed {
        logic       open;    // first byte of a sentence: open the frame
        logic [7:0] ftype;   // type byte captured at open
        logic [7:0] prefix;  // prefix captured at open
        logic [7:0] data;    // body byte
        logic       last;    // final body byte: close the frame
        logic [7:0] csum;    // checksum including this byte
    } job_t;

    typedef enum logic [3:0] {
        PH_HEAD,
        PH_FEND,
        PH_TYPE,
        PH_PREFIX,
        PH_DATA,
        PH_STAR,
        PH_HI,
        PH_LO,
        PH_CR,
        PH_LF,
        PH_CLOSE
    } phase_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CHAR_ZERO + {4'd0, v};
        else
            r = CHAR_A + {4'd0, v} - 8'd10;
        return r;
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == FEND) || (b == FESC);
    endfunction

    function automatic logic [7:0] escape_code(input logic [7:0] b);
        return (b == FEND) ? TFEND : TFESC;
    endfunction

endpackage

// File: rtl/knfe_front.sv
// ----------------------------------------------------------------------------
// knfe_front: input side of the frame encoder
// Holds the configuration registers, tracks the open sentence and its running
// checksum, and turns each body byte into a job record for the back end.
// ----------------------------------------------------------------------------
module knfe_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [knfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    input  logic [7:0]                    in_data,
    input  logic                          in_last,
    input  logic                          queue_full,
    output logic                          in_ready,
    output logic                          push,
    output knfe_pkg::job_t                job
);

    logic [7:0] frame_type_reg;
    logic [7:0] prefix_char_reg;
    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] csum;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // Checksum restarts with the first byte of a sentence
    assign csum = (in_frame_reg ? xor_reg : 8'h00) ^ in_data;

    always_comb
    begin
        job.open   = !in_frame_reg;
        job.ftype  = frame_type_reg;
        job.prefix = prefix_char_reg;
        job.data   = in_data;
        job.last   = in_last;
        job.csum   = csum;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        xor_next      = xor_reg;
        if (push)
        begin
            in_frame_next = !in_last;
            xor_next      = in_last ? 8'h00 : csum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg  <= knfe_pkg::FRAME_TYPE_RST;
            prefix_char_reg <= knfe_pkg::PREFIX_CHAR_RST;
            in_frame_reg    <= 1'b0;
            xor_reg         <= 8'h00;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            xor_reg      <= xor_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    knfe_pkg::CFG_FRAME_TYPE:  frame_type_reg  <= cfg_data;
                    knfe_pkg::CFG_PREFIX_CHAR: prefix_char_reg <= cfg_data;
                endcase
            end
        end
    end

endmodule

// File: rtl/knfe_queue.sv
// ----------------------------------------------------------------------------
// knfe_queue: short job queue between front and back
// Small register FIFO; the head entry is visible without a read latency.
// ----------------------------------------------------------------------------
module knfe_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  knfe_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           avail,
    output knfe_pkg::job_t head
);

    knfe_pkg::job_t                    mem_reg [knfe_pkg::QUEUE_DEPTH];
    logic [knfe_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [knfe_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [knfe_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [knfe_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [knfe_pkg::QCNT_W-1:0]       count_reg;
    logic [knfe_pkg::QCNT_W-1:0]       count_next;

    localparam logic [knfe_pkg::QCNT_W-1:0] CNT_FULL = knfe_pkg::QCNT_W'(knfe_pkg::QUEUE_DEPTH);
    localparam logic [knfe_pkg::QPTR_W-1:0] PTR_LAST =
        knfe_pkg::QPTR_W'(knfe_pkg::QUEUE_DEPTH - 1);

    assign full  = (count_reg == CNT_FULL);
    assign avail = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/knfe_back.sv
// ----------------------------------------------------------------------------
// knfe_back: byte sequencer of the frame encoder
// Walks the head job's phases, KISS-escaping type, prefix and body bytes,
// into an output register, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module knfe_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  knfe_pkg::job_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_done
);

    knfe_pkg::phase_t phase_reg;
    knfe_pkg::phase_t phase_next;
    knfe_pkg::phase_t cur;
    logic             esc_reg;
    logic             esc_next;
    logic             advance;
    logic [7:0]       raw_byte;
    logic             escapable;
    logic             step_done;
    logic             job_end;
    logic [7:0]       emit_byte;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             done_reg;

    // The head marker resolves to the first phase of the head job
    assign cur = (phase_reg == knfe_pkg::PH_HEAD)
                 ? (head.open ? knfe_pkg::PH_FEND : knfe_pkg::PH_DATA)
                 : phase_reg;

    assign advance = avail && (!valid_reg || out_ready);
    assign pop     = advance && job_end;

    // Output decode: byte to send for the current phase
    always_comb
    begin
        unique case (cur)
            knfe_pkg::PH_FEND:   raw_byte = knfe_pkg::FEND;
            knfe_pkg::PH_TYPE:   raw_byte = head.ftype;
            knfe_pkg::PH_PREFIX: raw_byte = head.prefix;
            knfe_pkg::PH_DATA:   raw_byte = head.data;
            knfe_pkg::PH_STAR:   raw_byte = knfe_pkg::CHAR_STAR;
            knfe_pkg::PH_HI:     raw_byte = knfe_pkg::hex_digit(head.csum[7:4]);
            knfe_pkg::PH_LO:     raw_byte = knfe_pkg::hex_digit(head.csum[3:0]);
            knfe_pkg::PH_CR:     raw_byte = knfe_pkg::CHAR_CR;
            knfe_pkg::PH_LF:     raw_byte = knfe_pkg::CHAR_LF;
            knfe_pkg::PH_CLOSE:  raw_byte = knfe_pkg::FEND;
            default:             raw_byte = 8'h00;
        endcase
        escapable = ((cur == knfe_pkg::PH_TYPE) || (cur == knfe_pkg::PH_PREFIX)
                     || (cur == knfe_pkg::PH_DATA)) && knfe_pkg::needs_escape(raw_byte);
        if (escapable)
            emit_byte = esc_reg ? knfe_pkg::escape_code(raw_byte) : knfe_pkg::FESC;
        else
            emit_byte = raw_byte;
        step_done = !escapable || esc_reg;
        job_end   = step_done && (((cur == knfe_pkg::PH_DATA) && !head.last)
                                  || (cur == knfe_pkg::PH_CLOSE));
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        if (advance)
        begin
            if (!step_done)
                esc_next = 1'b1;
            else
            begin
                esc_next = 1'b0;
                unique case (cur)
                    knfe_pkg::PH_FEND:   phase_next = knfe_pkg::PH_TYPE;
                    knfe_pkg::PH_TYPE:   phase_next = knfe_pkg::PH_PREFIX;
                    knfe_pkg::PH_PREFIX: phase_next = knfe_pkg::PH_DATA;
                    knfe_pkg::PH_DATA:
                        phase_next = head.last ? knfe_pkg::PH_STAR : knfe_pkg::PH_HEAD;
                    knfe_pkg::PH_STAR:   phase_next = knfe_pkg::PH_HI;
                    knfe_pkg::PH_HI:     phase_next = knfe_pkg::PH_LO;
                    knfe_pkg::PH_LO:     phase_next = knfe_pkg::PH_CR;
                    knfe_pkg::PH_CR:     phase_next = knfe_pkg::PH_LF;
                    knfe_pkg::PH_LF:     phase_next = knfe_pkg::PH_CLOSE;
                    knfe_pkg::PH_CLOSE:  phase_next = knfe_pkg::PH_HEAD;
                    default:             phase_next = knfe_pkg::PH_HEAD;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= knfe_pkg::PH_HEAD;
            esc_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            if (advance)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            byte_reg <= emit_byte;
            last_reg <= job_end;
            done_reg <= step_done && (cur == knfe_pkg::PH_CLOSE);
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_done  = done_reg;

endmodule

// File: rtl/kiss_nmea_frame_encoder.sv
// ----------------------------------------------------------------------------
// kiss_nmea_frame_encoder: KISS framing of NMEA sentences with checksum
// Takes sentence body bytes, opens a KISS frame with FEND, type byte and
// prefix, appends '*', hex checksum, CR, LF and a closing FEND, and escapes
// every byte between the frame ends.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Contents
//  s_*       in   s_tvalid/s_tready  tdata = body byte, tlast = last body byte
//  m_*       out  m_tvalid/m_tready  tdata = framed byte, tlast = last byte of
//                                    this input's run, tuser = closing FEND
//  cfg_*     in   cfg_we             index 0 frame_type, 1 prefix_char
//
//  The back sequencer emits one byte per cycle while a job is queued and m_*
//  is not stalled; a body byte goes out as 1 byte, 2 if escaped.
//  A two-entry job queue splits input from output, so input transfers go on
//  while the output register waits on m_tready; m_tready low holds m_* steady.
//  rst_n clears the open-frame flag, checksum, queue and sequencer at once.
//
module kiss_nmea_frame_encoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_byte
    output logic                          m_tlast,
    output logic                          m_tuser,   // [0] frame_done
    input  logic                          cfg_we,
    input  logic [knfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_avail;
    knfe_pkg::job_t front_job;
    knfe_pkg::job_t head_job;

    // Front: classify each body byte and fold it into the checksum
    knfe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .job        (front_job)
    );

    // Hold classified jobs until the sequencer takes them
    knfe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .full     (queue_full),
        .avail    (queue_avail),
        .head     (head_job)
    );

    // Back: expand each job into framed, escaped bytes
    knfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .avail     (queue_avail),
        .head      (head_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

endmodule
